### rtl/core/sau_pkg.sv
// Package for the shell argument unescaper.
// Holds the output beat kinds shared by the core and its port checker.
// No dependencies.
`default_nettype none

package sau_pkg;

    // byte_kind codes carried on m_axis_tuser
    localparam logic [1:0] KIND_CONTENT = 2'd0;
    localparam logic [1:0] KIND_SEP     = 2'd1;
    localparam logic [1:0] KIND_END     = 2'd2;

    // separator bytes
    localparam logic [7:0] SEP_NUL   = 8'h00;
    localparam logic [7:0] SEP_SPACE = 8'h20;

endpackage : sau_pkg

`default_nettype wire

### rtl/core/shell_argument_unescaper.sv
// Shell argument unescaper: quote tracking, blank collapsing, escape and
// UTF-8 decoding of a character stream, with an APB register port.
// Depends on sau_pkg.
`default_nettype none

// The block takes one raw byte of an argument string per input beat
// (s_axis_tdata), or an end marker (s_axis_tlast high, data ignored). It
// tracks quotes, turns each run of unquoted blanks into a single separator
// (NUL in word-split mode, space in single-string mode), decodes backslash
// escapes including \uXXXX and \u{...}, and sends every decoded code point
// as one to four UTF-8 bytes, one output beat per byte. An input beat gives
// zero to five output beats; m_axis_tlast marks the last beat of each input
// beat. An input beat is decoded in the cycle it is accepted and its beats
// are held in a six-entry result list, which drains one beat per cycle into
// the output register unless the output stalls. A new input beat is taken in
// the same cycle the last list entry moves out: one input beat per cycle as
// long as each yields at most one output beat and the output does not stall;
// a beat with more output holds the list until all of it has left. Beats with
// no output (blanks, quote marks, escape prefixes) pass at one per cycle.
// Registers: 0x0 split_mode (0 no quote tracking, 1 single string, 2 or 3 split
// into words; reset 2), 0x4 reject_specials (reset 0). Write registers only
// while no output is pending. words_seen counts words in the current string
// and saturates at 2^COUNT_BITS-1; special_error is sticky until the end
// marker, which also clears quoting, escape state and the word count.
module shell_argument_unescaper #(
    parameter int COUNT_BITS = 16
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // input stream
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [7:0]  s_axis_tdata,   // [7:0] char_byte
    input  wire         s_axis_tlast,   // end_of_text
    // output stream
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [7:0] out_byte, [23:8] words_seen,
                                        // [24] special_error, [31:25] zero
    output logic [1:0]  m_axis_tuser,   // [1:0] byte_kind
    output logic        m_axis_tlast,   // last_of_run
    // register port
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [2:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import sau_pkg::*;

    localparam int LIST_N = 6;

    // register indexes (paddr[2])
    localparam logic REG_SPLIT_MODE = 1'b0;
    localparam logic REG_REJECT     = 1'b1;

    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LBRACE = 8'h7B;

    typedef enum logic [1:0] {
        QC_BETWEEN = 2'd0,
        QC_WORD    = 2'd1,
        QC_SINGLE  = 2'd2,
        QC_DOUBLE  = 2'd3
    } t_quote;

    typedef enum logic [2:0] {
        EP_NONE      = 3'd0,
        EP_BACKSLASH = 3'd1,
        EP_U_FIRST   = 3'd2,
        EP_U_FIXED   = 3'd3,
        EP_U_BRACE   = 3'd4
    } t_esc;

    // configuration
    logic [1:0] r_mode;
    logic       r_reject;

    // string state
    t_quote                r_qc,    n_qc;
    t_esc                  r_ep,    n_ep;
    logic [23:0]           r_acc,   n_acc;
    logic [2:0]            r_dig,   n_dig;
    logic [COUNT_BITS-1:0] r_words, n_words;
    logic                  r_spec,  n_spec;

    // result list
    logic [7:0]  r_lbyte [LIST_N];
    logic [1:0]  r_lkind [LIST_N];
    logic [2:0]  r_lcnt;
    logic [2:0]  r_lidx;
    logic [15:0] r_lwords;
    logic        r_lspec;
    logic        r_lvld;

    // output register
    logic        r_ovld;
    logic [7:0]  r_obyte;
    logic [1:0]  r_okind;
    logic        r_olast;
    logic [15:0] r_owords;
    logic        r_ospec;

    // decode results
    logic [7:0]  e_byte [LIST_N];
    logic [1:0]  e_kind [LIST_N];
    logic [2:0]  e_cnt;
    logic [15:0] e_words;
    logic        e_spec;

    logic s_acc;
    logic cfg_wr;
    logic l_take;
    logic l_last;

    // ---------------------------------------------------------------
    // Register port
    // ---------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_comb begin
        unique case (paddr[2])
            REG_SPLIT_MODE: prdata = {30'd0, r_mode};
            REG_REJECT:     prdata = {31'd0, r_reject};
            default:        prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------
    // Decode one character: next state and the list of output bytes
    // ---------------------------------------------------------------
    always_comb begin
        logic [7:0]  c;
        logic        ending;
        logic        d_ok;
        logic [3:0]  d_val;
        logic [23:0] acc_sh;
        logic        code_en;
        logic [23:0] cv;
        logic [2:0]  code_n;
        logic [7:0]  cb [4];
        logic        plain_en;
        logic        pre_en;
        logic [7:0]  pre_byte;
        logic        quoted;
        logic        blank;
        logic        special;
        t_quote      qcw;
        logic [2:0]  cnt;

        c        = s_axis_tdata;
        ending   = s_axis_tlast;
        n_qc     = r_qc;
        n_ep     = r_ep;
        n_acc    = r_acc;
        n_dig    = r_dig;
        n_words  = r_words;
        n_spec   = r_spec;
        code_en  = 1'b0;
        cv       = '0;
        plain_en = 1'b0;
        pre_en   = 1'b0;
        pre_byte = c;
        cnt      = '0;
        for (int k = 0; k < LIST_N; k++) begin
            e_byte[k] = '0;
            e_kind[k] = KIND_CONTENT;
        end

        // hex digit, 0-9 a-f A-F only
        d_ok  = 1'b0;
        d_val = c[3:0];
        if (c >= 8'h30 && c <= 8'h39) begin
            d_ok = 1'b1;
        end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
            d_ok  = 1'b1;
            d_val = 4'(c[3:0] + 4'd9);
        end
        acc_sh = {r_acc[19:0], d_val};

        if (ending) begin
            if (r_ep == EP_BACKSLASH) begin
                pre_en   = 1'b1;
                pre_byte = CH_BSLASH;
            end else if (r_ep != EP_NONE) begin
                code_en = 1'b1;
                cv      = r_acc;
            end
        end else begin
            case (r_ep)
                EP_BACKSLASH: begin
                    n_ep = EP_NONE;
                    case (c)
                        8'h61:   pre_byte = 8'h07;   // a
                        8'h62:   pre_byte = 8'h08;   // b
                        8'h65:   pre_byte = 8'h1B;   // e
                        8'h66:   pre_byte = 8'h0C;   // f
                        8'h6E:   pre_byte = 8'h0A;   // n
                        8'h72:   pre_byte = 8'h0D;   // r
                        8'h74:   pre_byte = 8'h09;   // t
                        8'h76:   pre_byte = 8'h0B;   // v
                        default: pre_byte = c;
                    endcase
                    if (c == 8'h75) begin
                        // start of a \u sequence
                        n_ep  = EP_U_FIRST;
                        n_acc = '0;
                        n_dig = '0;
                    end else begin
                        pre_en = 1'b1;
                    end
                end
                EP_U_FIRST: begin
                    if (c == CH_LBRACE) begin
                        n_ep = EP_U_BRACE;
                    end else if (d_ok) begin
                        n_acc = {20'd0, d_val};
                        n_dig = 3'd1;
                        n_ep  = EP_U_FIXED;
                    end else begin
                        n_ep     = EP_NONE;
                        code_en  = 1'b1;
                        plain_en = 1'b1;
                    end
                end
                EP_U_FIXED: begin
                    if (d_ok) begin
                        n_acc = acc_sh;
                        n_dig = 3'(r_dig + 3'd1);
                        if (r_dig == 3'd3) begin
                            n_ep    = EP_NONE;
                            code_en = 1'b1;
                            cv      = acc_sh;
                        end
                    end else begin
                        n_ep     = EP_NONE;
                        code_en  = 1'b1;
                        cv       = r_acc;
                        plain_en = 1'b1;
                    end
                end
                EP_U_BRACE: begin
                    if (r_dig < 3'd6 && d_ok) begin
                        n_acc = acc_sh;
                        n_dig = 3'(r_dig + 3'd1);
                    end else begin
                        // swallow the closing byte
                        n_ep    = EP_NONE;
                        code_en = 1'b1;
                        cv      = r_acc;
                    end
                end
                default: begin
                    n_ep     = EP_NONE;
                    plain_en = 1'b1;
                end
            endcase
        end

        // UTF-8 encode
        code_n = 3'd1;
        cb[0]  = cv[7:0];
        cb[1]  = {2'b10, cv[5:0]};
        cb[2]  = {2'b10, cv[5:0]};
        cb[3]  = {2'b10, cv[5:0]};
        if (cv > 24'h00007F && cv <= 24'h0007FF) begin
            code_n = 3'd2;
            cb[0]  = {3'b110, cv[10:6]};
        end else if (cv > 24'h0007FF && cv <= 24'h00FFFF) begin
            code_n = 3'd3;
            cb[0]  = {4'b1110, cv[15:12]};
            cb[1]  = {2'b10, cv[11:6]};
        end else if (cv > 24'h00FFFF) begin
            code_n = 3'd4;
            // lead bits beyond six merge into the lead byte
            cb[0]  = 8'hF0 | {2'b00, cv[23:18]};
            cb[1]  = {2'b10, cv[17:12]};
            cb[2]  = {2'b10, cv[11:6]};
        end

        if (pre_en) begin
            e_byte[cnt] = pre_byte;
            cnt         = 3'(cnt + 3'd1);
        end
        if (code_en) begin
            for (int k = 0; k < 4; k++) begin
                if (3'(k) < code_n) begin
                    e_byte[cnt] = cb[k];
                    cnt         = 3'(cnt + 3'd1);
                end
            end
        end

        // plain character handling
        quoted  = (r_qc == QC_SINGLE) || (r_qc == QC_DOUBLE);
        blank   = (c == CH_SPACE) || (c == CH_TAB);
        special = (c == 8'h24) || (c == 8'h26) || (c == 8'h7C) ||
                  (c == 8'h3C) || (c == 8'h3E);
        qcw     = r_qc;
        if (plain_en) begin
            if (!quoted && blank) begin
                n_qc = QC_BETWEEN;
            end else begin
                if (r_qc == QC_BETWEEN) begin
                    qcw = QC_WORD;
                    if (r_words != '0) begin
                        e_byte[cnt] = (r_mode >= 2'd2) ? SEP_NUL : SEP_SPACE;
                        e_kind[cnt] = KIND_SEP;
                        cnt         = 3'(cnt + 3'd1);
                    end
                    if (r_words != '1) begin
                        n_words = r_words + COUNT_BITS'(1);
                    end
                end
                n_qc = qcw;
                if ((c == CH_SQUOTE || c == CH_DQUOTE) && !quoted && r_mode >= 2'd1) begin
                    n_qc = (c == CH_SQUOTE) ? QC_SINGLE : QC_DOUBLE;
                end else if ((qcw == QC_SINGLE && c == CH_SQUOTE) ||
                             (qcw == QC_DOUBLE && c == CH_DQUOTE)) begin
                    n_qc = QC_WORD;
                end else if (c == CH_BSLASH) begin
                    n_ep = EP_BACKSLASH;
                end else begin
                    if (r_reject && !quoted && special) begin
                        n_spec = 1'b1;
                    end
                    e_byte[cnt] = c;
                    cnt         = 3'(cnt + 3'd1);
                end
            end
        end

        e_words = 16'(n_words);
        e_spec  = n_spec;

        if (ending) begin
            e_byte[cnt] = '0;
            e_kind[cnt] = KIND_END;
            cnt         = 3'(cnt + 3'd1);
            // clear the string context
            n_qc    = QC_BETWEEN;
            n_ep    = EP_NONE;
            n_acc   = '0;
            n_dig   = '0;
            n_words = '0;
            n_spec  = 1'b0;
        end
        e_cnt = cnt;
    end

    // ---------------------------------------------------------------
    // Handshake: list drains into the output register, the next input
    // beat enters as the last list entry leaves
    // ---------------------------------------------------------------
    assign l_take        = r_lvld && (!r_ovld || m_axis_tready);
    assign l_last        = (r_lidx == 3'(r_lcnt - 3'd1));
    assign s_axis_tready = !r_lvld || (l_take && l_last);
    assign s_acc         = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= 2'd2;
            r_reject <= 1'b0;
            r_qc     <= QC_BETWEEN;
            r_ep     <= EP_NONE;
            r_acc    <= '0;
            r_dig    <= '0;
            r_words  <= '0;
            r_spec   <= 1'b0;
            r_lvld   <= 1'b0;
            r_lidx   <= '0;
            r_lcnt   <= '0;
            r_ovld   <= 1'b0;
        end else begin
            if (cfg_wr) begin
                unique case (paddr[2])
                    REG_SPLIT_MODE: r_mode   <= pwdata[1:0];
                    REG_REJECT:     r_reject <= pwdata[0];
                    default:        ;
                endcase
            end

            // output register
            if (l_take) begin
                r_ovld <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovld <= 1'b0;
            end

            // accept the next character
            if (s_acc) begin
                r_qc    <= n_qc;
                r_ep    <= n_ep;
                r_acc   <= n_acc;
                r_dig   <= n_dig;
                r_words <= n_words;
                r_spec  <= n_spec;
            end

            // load, advance or drop the list; a new load only happens while the list is
            // empty or as the last entry leaves, so it replaces the drop
            if (s_acc && e_cnt != 3'd0) begin
                r_lvld <= 1'b1;
                r_lidx <= '0;
                r_lcnt <= e_cnt;
            end else if (l_take) begin
                if (l_last) begin
                    r_lvld <= 1'b0;
                end else begin
                    r_lidx <= 3'(r_lidx + 3'd1);
                end
            end
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            for (int k = 0; k < LIST_N; k++) begin
                r_lbyte[k] <= e_byte[k];
                r_lkind[k] <= e_kind[k];
            end
            r_lwords <= e_words;
            r_lspec  <= e_spec;
        end
        if (l_take) begin
            r_obyte  <= r_lbyte[r_lidx];
            r_okind  <= r_lkind[r_lidx];
            r_olast  <= l_last;
            r_owords <= r_lwords;
            r_ospec  <= r_lspec;
        end
    end

    assign m_axis_tvalid = r_ovld;
    assign m_axis_tdata  = {7'd0, r_ospec, r_owords, r_obyte};
    assign m_axis_tuser  = r_okind;
    assign m_axis_tlast  = r_olast;

endmodule : shell_argument_unescaper

`default_nettype wire

### rtl/core/sau_checker.sv
// Port checker for the shell argument unescaper, bound to the top level.
// Depends on sau_pkg and shell_argument_unescaper.
`default_nettype none

module sau_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        m_axis_tvalid,
    input wire        m_axis_tready,
    input wire [31:0] m_axis_tdata,
    input wire [1:0]  m_axis_tuser,
    input wire        m_axis_tlast
);
    import sau_pkg::*;

    // an end-of-text beat always closes its run
    a_end_is_last : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == KIND_END |-> m_axis_tlast)
        else $error("end beat without tlast");

    // end beat carries a zero byte
    a_end_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == KIND_END |-> m_axis_tdata[7:0] == 8'h00)
        else $error("end beat with nonzero byte");

    // separators are NUL or space only
    a_sep_byte : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == KIND_SEP |->
            m_axis_tdata[7:0] == SEP_NUL || m_axis_tdata[7:0] == SEP_SPACE)
        else $error("bad separator byte");

    // a stalled beat holds
    a_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("output beat changed under stall");

endmodule : sau_checker

bind shell_argument_unescaper sau_checker u_sau_checker (.*);

`default_nettype wire

### dv/sau_output_check.sv
// Output checker for the shell argument unescaper: watches the input, output and register
// channels, predicts every output beat and compares it field by field.
// Depends on sau_pkg for the beat kinds and separator bytes.
module sau_output_check #(
    parameter int         COUNT_BITS  = 16,
    parameter logic [2:0] ADDR_SPLIT  = 3'h0,
    parameter logic [2:0] ADDR_REJECT = 3'h4
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    input  wire         s_axis_tready,
    input  wire  [7:0]  s_axis_tdata,   // [7:0] char_byte
    input  wire         s_axis_tlast,   // end_of_text
    input  wire         m_axis_tvalid,
    input  wire         m_axis_tready,
    input  wire  [31:0] m_axis_tdata,   // [7:0] out_byte, [23:8] words_seen,
                                        // [24] special_error, [31:25] zero
    input  wire  [1:0]  m_axis_tuser,   // [1:0] byte_kind
    input  wire         m_axis_tlast,   // last_of_run
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [2:0]  paddr,
    input  wire  [31:0] pwdata,
    input  wire         pready,
    output int          o_fail_count,
    output int          o_pending_beats
);
    timeunit 1ns;
    timeprecision 1ps;
    import sau_pkg::*;

    localparam logic [1:0] MODE_STRING  = 2'd1;
    localparam logic [1:0] MODE_WORDS   = 2'd2;

    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LBRACE = 8'h7B;

    localparam logic [63:0] WORD_LIMIT = (64'd1 << COUNT_BITS) - 64'd1;
    localparam int          MAX_BEATS  = 6;
    localparam int          MAX_PRINTS = 40;

    typedef enum logic [1:0] {Q_BETWEEN, Q_WORD, Q_SINGLE, Q_DOUBLE} quote_t;
    typedef enum logic [2:0] {E_NONE, E_BACKSLASH, E_U_FIRST, E_U_FIXED, E_U_BRACE} esc_t;

    typedef struct packed {
        logic [7:0]  data;
        logic [1:0]  kind;
        logic [15:0] words;
        logic        err;
        logic        last;
    } out_beat_t;

    out_beat_t expected_beats[$];
    out_beat_t step_beats[$];
    out_beat_t want;

    logic [1:0]  split_mode;
    logic        reject_specials;
    quote_t      quote_ctx;
    esc_t        esc_phase;
    logic [23:0] code_acc;
    logic [2:0]  ndigits;
    logic [63:0] word_count;
    logic        err_flag;

    task automatic report_mismatch(input string msg);
        if (o_fail_count < MAX_PRINTS)
            $display("[%0t] mismatch: %s", $realtime, msg);
        o_fail_count++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] exp_val);
        if (got !== exp_val)
            report_mismatch($sformatf("%s got %0h, wanted %0h", name, got, exp_val));
    endtask

    task automatic clear_string();
        quote_ctx  = Q_BETWEEN;
        esc_phase  = E_NONE;
        code_acc   = '0;
        ndigits    = '0;
        word_count = '0;
        err_flag   = 1'b0;
    endtask

    function automatic int nibble_of(input logic [7:0] c);
        if (c >= "0" && c <= "9") return int'(c - 8'h30);
        if (c >= "a" && c <= "f") return int'(c - 8'h57);
        if (c >= "A" && c <= "F") return int'(c - 8'h37);
        return -1;
    endfunction

    // Drop bytes beyond the per-item result limit.
    task automatic emit_byte(input logic [7:0] b, input logic [1:0] k);
        out_beat_t beat;
        if (step_beats.size() < MAX_BEATS) begin
            beat      = '0;
            beat.data = b;
            beat.kind = k;
            step_beats.push_back(beat);
        end
    endtask

    // UTF-8 encode; the four-byte lead absorbs any bits above 21 and wraps to 8 bits.
    task automatic emit_code(input logic [23:0] cp);
        logic [31:0] v;
        logic [31:0] enc;
        int          nb;
        v = {8'h00, cp};
        if (v <= 32'h7F)        nb = 1;
        else if (v <= 32'h7FF)  nb = 2;
        else if (v <= 32'hFFFF) nb = 3;
        else                    nb = 4;
        if (nb == 1) begin
            emit_byte(v[7:0], KIND_CONTENT);
        end else begin
            enc = (32'hF0 << (4 - nb)) | (v >> (6 * (nb - 1)));
            emit_byte(enc[7:0], KIND_CONTENT);
            for (int k = 2; k <= nb; k++) begin
                enc = 32'h80 | ((v >> (6 * (nb - k))) & 32'h3F);
                emit_byte(enc[7:0], KIND_CONTENT);
            end
        end
    endtask

    task automatic plain_char(input logic [7:0] c);
        logic quoted;
        quoted = (quote_ctx == Q_SINGLE) || (quote_ctx == Q_DOUBLE);
        if (!quoted && (c == CH_SPACE || c == CH_TAB)) begin
            quote_ctx = Q_BETWEEN;
            return;
        end
        if (quote_ctx == Q_BETWEEN) begin
            quote_ctx = Q_WORD;
            if (word_count != 0)
                emit_byte(split_mode >= MODE_WORDS ? SEP_NUL : SEP_SPACE, KIND_SEP);
            if (word_count < WORD_LIMIT)
                word_count++;
        end
        if ((c == CH_SQUOTE || c == CH_DQUOTE) && !quoted && split_mode >= MODE_STRING) begin
            quote_ctx = (c == CH_SQUOTE) ? Q_SINGLE : Q_DOUBLE;
            return;
        end
        if ((quote_ctx == Q_SINGLE && c == CH_SQUOTE) ||
            (quote_ctx == Q_DOUBLE && c == CH_DQUOTE)) begin
            quote_ctx = Q_WORD;
            return;
        end
        if (c == CH_BSLASH) begin
            esc_phase = E_BACKSLASH;
            return;
        end
        if (reject_specials && !quoted &&
            (c == "$" || c == "&" || c == "|" || c == "<" || c == ">"))
            err_flag = 1'b1;
        emit_byte(c, KIND_CONTENT);
    endtask

    task automatic simple_escape(input logic [7:0] c);
        logic [7:0] b;
        b = c;
        case (c)
            "a": b = 8'h07;
            "b": b = 8'h08;
            "e": b = 8'h1B;
            "f": b = 8'h0C;
            "n": b = 8'h0A;
            "r": b = 8'h0D;
            "t": b = 8'h09;
            "v": b = 8'h0B;
            "u": begin
                esc_phase = E_U_FIRST;
                code_acc  = '0;
                ndigits   = '0;
                return;
            end
            default: ;
        endcase
        emit_byte(b, KIND_CONTENT);
    endtask

    // Advance the string state by one input beat and queue the beats it yields.
    task automatic predict_item(input logic [7:0] c, input logic ending);
        int d;
        int n;
        step_beats.delete();
        if (ending) begin
            if (esc_phase == E_BACKSLASH)
                emit_byte(CH_BSLASH, KIND_CONTENT);
            else if (esc_phase >= E_U_FIRST)
                emit_code(code_acc);
            emit_byte(8'h00, KIND_END);
        end else begin
            d = nibble_of(c);
            case (esc_phase)
                E_BACKSLASH: begin
                    esc_phase = E_NONE;
                    simple_escape(c);
                end
                E_U_FIRST: begin
                    if (c == CH_LBRACE) begin
                        esc_phase = E_U_BRACE;
                    end else if (d >= 0) begin
                        code_acc  = 24'(d);
                        ndigits   = 3'd1;
                        esc_phase = E_U_FIXED;
                    end else begin
                        esc_phase = E_NONE;
                        emit_code('0);
                        plain_char(c);
                    end
                end
                E_U_FIXED: begin
                    if (d >= 0) begin
                        code_acc = {code_acc[19:0], 4'(d)};
                        ndigits++;
                        if (ndigits >= 3'd4) begin
                            esc_phase = E_NONE;
                            emit_code(code_acc);
                        end
                    end else begin
                        esc_phase = E_NONE;
                        emit_code(code_acc);
                        plain_char(c);
                    end
                end
                E_U_BRACE: begin
                    // the byte after the digits closes the escape, whatever it is
                    if (ndigits < 3'd6 && d >= 0) begin
                        code_acc = {code_acc[19:0], 4'(d)};
                        ndigits++;
                    end else begin
                        esc_phase = E_NONE;
                        emit_code(code_acc);
                    end
                end
                default: begin
                    esc_phase = E_NONE;
                    plain_char(c);
                end
            endcase
        end
        n = step_beats.size();
        for (int i = 0; i < n; i++) begin
            step_beats[i].words = word_count[15:0];
            step_beats[i].err   = err_flag;
            step_beats[i].last  = (i == n - 1);
            expected_beats.push_back(step_beats[i]);
        end
        if (ending)
            clear_string();
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            split_mode      = MODE_WORDS;
            reject_specials = 1'b0;
            clear_string();
            expected_beats.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                if (paddr == ADDR_SPLIT)
                    split_mode = pwdata[1:0];
                else if (paddr == ADDR_REJECT)
                    reject_specials = pwdata[0];
            end
            if (s_axis_tvalid && s_axis_tready)
                predict_item(s_axis_tdata, s_axis_tlast);
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_beats.size() == 0) begin
                    report_mismatch($sformatf("output beat %08h/%0d/%0b with none expected",
                                              m_axis_tdata, m_axis_tuser, m_axis_tlast));
                end else begin
                    want = expected_beats.pop_front();
                    check_field("out_byte", 32'(m_axis_tdata[7:0]), 32'(want.data));
                    check_field("words_seen", 32'(m_axis_tdata[23:8]), 32'(want.words));
                    check_field("special_error", 32'(m_axis_tdata[24]), 32'(want.err));
                    check_field("tdata pad", 32'(m_axis_tdata[31:25]), '0);
                    check_field("byte_kind", 32'(m_axis_tuser), 32'(want.kind));
                    check_field("last_of_run", 32'(m_axis_tlast), 32'(want.last));
                end
            end
        end
        o_pending_beats = expected_beats.size();
    end

endmodule

### dv/tb.sv
// Testbench top for the shell argument unescaper: clock, reset, register writes and
// input/output stream traffic; the verdict comes from sau_output_check.
// Depends on the RTL (sau_pkg, shell_argument_unescaper) and dv/sau_output_check.sv.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int         COUNT_BITS     = 16;
    localparam logic [2:0] ADDR_SPLIT     = 3'h0;
    localparam logic [2:0] ADDR_REJECT    = 3'h4;
    localparam int         CYCLE_LIMIT    = 400000;
    localparam int         HOLDOFF_CYCLES = 300;
    localparam int         SETTLE_CYCLES  = 8;
    localparam int         NUM_PHASES     = 8;
    localparam int         PHASE_ITEMS    = 50;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic [7:0]  s_axis_tdata  = '0;     // [7:0] char_byte
    logic        s_axis_tlast  = 1'b0;   // end_of_text
    logic        m_axis_tready = 1'b0;
    logic        psel          = 1'b0;
    logic        penable       = 1'b0;
    logic        pwrite        = 1'b0;
    logic [2:0]  paddr         = '0;
    logic [31:0] pwdata        = '0;

    wire         s_axis_tready;
    wire         m_axis_tvalid;
    wire  [31:0] m_axis_tdata;           // [7:0] out_byte, [23:8] words_seen,
                                         // [24] special_error, [31:25] zero
    wire  [1:0]  m_axis_tuser;           // [1:0] byte_kind
    wire         m_axis_tlast;           // last_of_run
    wire  [31:0] prdata;
    wire         pready;

    int          fail_count;
    int          pending_beats;
    int          cycle_count   = 0;
    int          items_sent    = 0;
    int          send_idle_pct = 0;
    int          stall_pct     = 0;
    bit          holdoff_req   = 1'b0;
    bit          holdoff_done  = 1'b0;

    shell_argument_unescaper #(
        .COUNT_BITS(COUNT_BITS)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tlast (s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .m_axis_tlast (m_axis_tlast),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    sau_output_check #(
        .COUNT_BITS (COUNT_BITS),
        .ADDR_SPLIT (ADDR_SPLIT),
        .ADDR_REJECT(ADDR_REJECT)
    ) u_output_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .s_axis_tlast   (s_axis_tlast),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .m_axis_tuser   (m_axis_tuser),
        .m_axis_tlast   (m_axis_tlast),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .pready         (pready),
        .o_fail_count   (fail_count),
        .o_pending_beats(pending_beats)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Abort a hung run: the slowest legal run stays far below this count.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Output side: stall at the phase rate, or hold off once for a long stretch on
    // request so the result list fills and the block pushes back on its input.
    initial begin
        forever begin
            @(posedge i_clk);
            if (holdoff_req && !holdoff_done) begin
                m_axis_tready <= 1'b0;
                repeat (HOLDOFF_CYCLES) @(posedge i_clk);
                holdoff_done = 1'b1;
            end else begin
                m_axis_tready <= ($urandom_range(99) < stall_pct) ? 1'b0 : 1'b1;
            end
        end
    end

    // Offer one input beat and hold it until accepted. Keep tvalid high on return so a
    // back-to-back beat does not drop it; idle gaps and drain lower it.
    task automatic send_item(input logic [7:0] c, input logic ending);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        s_axis_tlast  <= ending;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        items_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_item(s[i], 1'b0);
    endtask

    // Terminator: the data byte is don't-care, so make it random.
    task automatic send_end();
        send_item(8'($urandom_range(255)), 1'b1);
    endtask

    function automatic logic [7:0] hex_char();
        string digits;
        digits = "0123456789abcdefABCDEF";
        return digits[$urandom_range(21)];
    endfunction

    // One escape sequence, well formed most of the time; the braced form sometimes runs
    // past six digits or closes on an arbitrary byte.
    task automatic send_escape();
        string simple;
        simple = "abefnrtv";
        send_item(8'h5C, 1'b0);
        case ($urandom_range(3))
            0: send_item(simple[$urandom_range(7)], 1'b0);
            1: send_item(8'($urandom_range(255)), 1'b0);
            2: begin
                send_item("u", 1'b0);
                repeat ($urandom_range(4)) send_item(hex_char(), 1'b0);
            end
            default: begin
                send_item("u", 1'b0);
                send_item("{", 1'b0);
                repeat ($urandom_range(7)) send_item(hex_char(), 1'b0);
                if ($urandom_range(3) == 0)
                    send_item(8'($urandom_range(255)), 1'b0);
                else
                    send_item("}", 1'b0);
            end
        endcase
    endtask

    // One argument string built from word characters, blanks, quotes, escapes, shell
    // specials and raw noise bytes, then the terminator.
    task automatic send_string();
        string specials;
        int    pick;
        specials = "$&|<>";
        repeat ($urandom_range(3, 20)) begin
            pick = $urandom_range(99);
            if (pick < 35) begin
                case ($urandom_range(2))
                    0: send_item(8'("a" + $urandom_range(25)), 1'b0);
                    1: send_item(8'("A" + $urandom_range(25)), 1'b0);
                    default: send_item(8'("0" + $urandom_range(9)), 1'b0);
                endcase
            end else if (pick < 50) begin
                send_item($urandom_range(1) ? 8'h20 : 8'h09, 1'b0);
            end else if (pick < 58) begin
                send_item($urandom_range(1) ? 8'h27 : 8'h22, 1'b0);
            end else if (pick < 80) begin
                send_escape();
            end else if (pick < 88) begin
                send_item(specials[$urandom_range(4)], 1'b0);
            end else begin
                send_item(8'($urandom_range(255)), 1'b0);
            end
        end
        send_end();
    endtask

    // Drop tvalid, wait for every predicted beat, then let in-flight work finish.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_beats != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Setup cycle, access cycle, then an idle gap with psel low, so back-to-back writes never
    // retarget psel within one step.
    task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    initial begin
        int goal;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed, at reset settings: byte extremes, blank collapse, single quotes,
        // simple escape, short \u cut by a non-hex byte, six-digit braced four-byte code
        // point, then an end right after a backslash and inside a braced escape.
        send_item(8'h00, 1'b0);
        send_item(8'hFF, 1'b0);
        send_text(" \t'a b'\\n\\u7g\\u{FFFFFF}x$");
        send_end();
        send_text("\\");
        send_end();
        send_text("\\u{1");
        send_end();
        settle();

        // Walk every split mode with and without special rejection; the idle pattern
        // steps through none, sender gaps, receiver stalls, then both.
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            reg_write(ADDR_SPLIT, 32'(phase % 4));
            reg_write(ADDR_REJECT, 32'(phase / 4));
            case (phase / 2)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 70; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 70; end
                default: begin send_idle_pct = 18; stall_pct = 18; end
            endcase
            // long output hold-off while input keeps coming at full rate
            if (phase == 1)
                holdoff_req = 1'b1;
            goal = items_sent + PHASE_ITEMS;
            while (items_sent < goal) send_string();
            settle();
        end

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
